// ===== src/rrq_pkg.sv =====
// Shared types and defaults for the round-robin ready queue.
// No dependencies; used by rrq_cell and round_robin_ready_queue_unit.
package rrq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT  = 16;
   localparam int TASK_ID_BITS_DEFAULT = 8;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_YIELD = 2'd1,
      ACT_TAKE  = 2'd2,
      ACT_READ  = 2'd3
   } rrq_action_type;

   // per-cycle command broadcast to every cell of the queue
   typedef struct packed {
      logic shift;   // every cell takes its back neighbor's entry
      logic write;   // the cell at the write position loads the write data
   } rrq_cell_ctrl_type;

endpackage

// ===== src/round_robin_ready_queue_unit.sv =====
// Top level of the round-robin ready queue (task scheduler deque).
// Depends on rrq_pkg and a chain of rrq_cell slots.
//
//   channel   ports                 handshake
//   request   start, busy, req_*    taken when start && !busy
//   response  rsp_valid, rsp_*      one-cycle strobe, no back-pressure
//
// State updates at the accepting edge and the response strobes in the following
// cycle. busy stays low, so a new transaction may be issued every cycle. The
// queue is a row of cells with the front in cell 0; a pop from the front shifts
// the whole row one place. Reset (synchronous) clears count, current task,
// postponed and valid flags; cell contents and the other response bits are
// don't-care until written. The receiver cannot stall the response.
module round_robin_ready_queue_unit #(
   parameter int QUEUE_DEPTH  = rrq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TASK_ID_BITS = rrq_pkg::TASK_ID_BITS_DEFAULT,
   parameter int CNT_BITS     = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_action,
   input  logic [TASK_ID_BITS-1:0]  req_task_id,
   input  logic                     req_current_running,
   input  logic                     req_switch_locked,
   output logic                     rsp_valid,
   output logic [TASK_ID_BITS-1:0]  rsp_current_task,
   output logic                     rsp_current_valid,
   output logic [TASK_ID_BITS-1:0]  rsp_taken_task,
   output logic                     rsp_taken_valid,
   output logic                     rsp_switched,
   output logic                     rsp_postponed,
   output logic                     rsp_dropped,
   output logic [CNT_BITS-1:0]      rsp_ready_count
);
   import rrq_pkg::*;

   localparam int POS_BITS = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

   // architectural state
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [TASK_ID_BITS-1:0]  running_task_ff, running_task_in;
   logic                     running_valid_ff, running_valid_in;
   logic                     postponed_ff, postponed_in;

   // per-transaction response bits
   logic                     rsp_valid_ff;
   logic [TASK_ID_BITS-1:0]  taken_task_ff, taken_task_in;
   logic                     taken_valid_ff, taken_valid_in;
   logic                     switched_ff, switched_in;
   logic                     dropped_ff, dropped_in;

   // cell chain
   rrq_cell_ctrl_type        cell_ctrl;
   logic [POS_BITS-1:0]      wr_pos;
   logic [TASK_ID_BITS-1:0]  wr_data;
   logic [TASK_ID_BITS-1:0]  entries [QUEUE_DEPTH];

   logic                     accept;
   logic                     queue_empty;
   logic                     queue_full;
   logic                     requeue;
   logic [POS_BITS-1:0]      back_pos;
   rrq_action_type           action;

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign action      = rrq_action_type'(req_action);
   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == FULL_COUNT);
   // an absent current task counts as not running
   assign requeue     = running_valid_ff && req_current_running;
   assign back_pos    = POS_BITS'(count_ff - 1'b1);

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic [TASK_ID_BITS-1:0] neighbor;
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign neighbor = '0;
         end else begin : g_mid
            assign neighbor = entries[gi+1];
         end
         rrq_cell #(
            .ID_BITS  (TASK_ID_BITS),
            .POS_BITS (POS_BITS),
            .POSITION (gi)
         ) u_cell (
            .clock          (clock),
            .ctrl           (cell_ctrl),
            .wr_pos         (wr_pos),
            .wr_data        (wr_data),
            .neighbor_entry (neighbor),
            .entry          (entries[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in         = count_ff;
      running_task_in  = running_task_ff;
      running_valid_in = running_valid_ff;
      postponed_in     = postponed_ff;
      taken_task_in    = '0;
      taken_valid_in   = 1'b0;
      switched_in      = 1'b0;
      dropped_in       = 1'b0;
      cell_ctrl.shift  = 1'b0;
      cell_ctrl.write  = 1'b0;
      wr_pos           = POS_BITS'(count_ff);
      wr_data          = req_task_id;
      if (accept) begin
         case (action)
            ACT_ADD: begin
               if (queue_full) begin
                  dropped_in = 1'b1;
               end else if (queue_empty && !req_switch_locked) begin
                  // new task goes straight to current; old one re-queued at slot 0
                  running_task_in  = req_task_id;
                  running_valid_in = 1'b1;
                  postponed_in     = 1'b0;
                  switched_in      = 1'b1;
                  if (requeue) begin
                     cell_ctrl.write = 1'b1;
                     wr_data         = running_task_ff;
                     count_in        = CNT_BITS'(1);
                  end
               end else begin
                  cell_ctrl.write = 1'b1;
                  count_in        = count_ff + 1'b1;
                  if (queue_empty) begin
                     postponed_in = 1'b1;   // locked yield after first add
                  end
               end
            end
            ACT_YIELD: begin
               if (req_switch_locked) begin
                  postponed_in = 1'b1;
               end else if (!queue_empty) begin
                  running_task_in  = entries[0];
                  running_valid_in = 1'b1;
                  postponed_in     = 1'b0;
                  switched_in      = 1'b1;
                  cell_ctrl.shift  = 1'b1;
                  if (requeue) begin
                     // shift and append together: count is unchanged
                     cell_ctrl.write = 1'b1;
                     wr_pos          = back_pos;
                     wr_data         = running_task_ff;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            ACT_TAKE: begin
               if (!queue_empty) begin
                  taken_task_in  = entries[back_pos];
                  taken_valid_in = 1'b1;
                  count_in       = count_ff - 1'b1;
               end
            end
            ACT_READ: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         running_task_ff  <= '0;
         running_valid_ff <= 1'b0;
         postponed_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         count_ff         <= count_in;
         running_task_ff  <= running_task_in;
         running_valid_ff <= running_valid_in;
         postponed_ff     <= postponed_in;
         rsp_valid_ff     <= accept;
      end
   end

   always_ff @(posedge clock) begin
      taken_task_ff  <= taken_task_in;
      taken_valid_ff <= taken_valid_in;
      switched_ff    <= switched_in;
      dropped_ff     <= dropped_in;
   end

   // state registers already hold the post-transaction values
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_task  = running_task_ff;
   assign rsp_current_valid = running_valid_ff;
   assign rsp_taken_task    = taken_task_ff;
   assign rsp_taken_valid   = taken_valid_ff;
   assign rsp_switched      = switched_ff;
   assign rsp_postponed     = postponed_ff;
   assign rsp_dropped       = dropped_ff;
   assign rsp_ready_count   = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("ready count beyond queue depth");

   a_switch_has_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> rsp_current_valid && !rsp_postponed)
      else $error("switch without current task or with postponed set");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_ready_count == FULL_COUNT)
      else $error("drop reported with room in the queue");

   a_take_pops: assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_TAKE && !queue_empty
      |=> rsp_taken_valid && count_ff == $past(count_ff) - 1'b1)
      else $error("take did not pop the back entry");

endmodule

// ===== src/rrq_cell.sv =====
// One slot of the ready queue: holds a task number, shifts toward the front.
// Depends on rrq_pkg for the cell command struct.
module rrq_cell #(
   parameter int ID_BITS  = rrq_pkg::TASK_ID_BITS_DEFAULT,
   parameter int POS_BITS = 4,
   parameter int POSITION = 0
) (
   input  logic                          clock,
   input  rrq_pkg::rrq_cell_ctrl_type    ctrl,
   input  logic [POS_BITS-1:0]           wr_pos,
   input  logic [ID_BITS-1:0]            wr_data,
   input  logic [ID_BITS-1:0]            neighbor_entry,
   output logic [ID_BITS-1:0]            entry
);
   import rrq_pkg::*;

   localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(POSITION);

   logic [ID_BITS-1:0] entry_ff;
   logic [ID_BITS-1:0] entry_in;

   // write lands at the post-shift position, so it wins over the shift
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.write && (wr_pos == MY_POS)) begin
         entry_in = wr_data;
      end else if (ctrl.shift) begin
         entry_in = neighbor_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== tb/round_robin_ready_queue_unit_test.sv =====
// Testbench for round_robin_ready_queue_unit: a scoreboard class predicts the scheduler's deque.
// Random command bursts plus directed corner cases drive the block; needs rrq_pkg and the RTL.
`timescale 1ns / 100ps

typedef struct packed {
   logic [7:0] cur_task_id;
   logic       current_valid;
   logic [7:0] taken_task;
   logic       taken_valid;
   logic       switched;
   logic       postponed;
   logic       dropped;
   logic [4:0] ready_count;
} sched_result_type;

class sched_scoreboard;
   logic [7:0]       ready_tasks[$];
   logic [7:0]       cur_task;
   bit               cur_valid;
   bit               postponed_flag;
   sched_result_type awaited[$];
   int unsigned      mismatches;
   int unsigned      commands;
   int unsigned      switches;
   int unsigned      takes_hit;
   int unsigned      drops;
   int unsigned      peak_depth;

   // yield step; returns 1 when a switch happened
   function bit run_yield(bit still_running, bit locked);
      logic [7:0] next_task;
      if (locked) begin
         postponed_flag = 1'b1;
         return 1'b0;
      end
      if (ready_tasks.size() == 0)
         return 1'b0;
      next_task = ready_tasks[0];
      ready_tasks.delete(0);
      // an absent current task never goes back to the queue
      if (cur_valid && still_running)
         ready_tasks.insert(ready_tasks.size(), cur_task);
      cur_task       = next_task;
      cur_valid      = 1'b1;
      postponed_flag = 1'b0;
      return 1'b1;
   endfunction

   function void note_command(rrq_pkg::rrq_action_type act, logic [7:0] id,
                              bit still_running, bit locked);
      sched_result_type res;
      res = '0;
      case (act)
         rrq_pkg::ACT_ADD: begin
            if (ready_tasks.size() >= rrq_pkg::QUEUE_DEPTH_DEFAULT) begin
               res.dropped = 1'b1;
            end else begin
               ready_tasks.insert(ready_tasks.size(), id);
               if (ready_tasks.size() == 1)
                  res.switched = run_yield(still_running, locked);
            end
         end
         rrq_pkg::ACT_YIELD: res.switched = run_yield(still_running, locked);
         rrq_pkg::ACT_TAKE: begin
            if (ready_tasks.size() > 0) begin
               res.taken_task  = ready_tasks[ready_tasks.size() - 1];
               res.taken_valid = 1'b1;
               ready_tasks.delete(ready_tasks.size() - 1);
            end
         end
         default: ;
      endcase
      res.cur_task_id   = cur_valid ? cur_task : 8'd0;
      res.current_valid = cur_valid;
      res.postponed     = postponed_flag;
      res.ready_count   = 5'(ready_tasks.size());
      awaited.insert(awaited.size(), res);
      commands++;
      if (res.switched) switches++;
      if (res.taken_valid) takes_hit++;
      if (res.dropped) drops++;
      if (ready_tasks.size() > peak_depth) peak_depth = ready_tasks.size();
   endfunction

   function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function void check_response(sched_result_type got);
      sched_result_type want;
      if (awaited.size() == 0) begin
         $error("response strobe with no transaction outstanding");
         mismatches++;
         return;
      end
      want = awaited[0];
      awaited.delete(0);
      compare_field("rsp_current_task", want.cur_task_id, got.cur_task_id);
      compare_field("current_valid", 8'(want.current_valid), 8'(got.current_valid));
      compare_field("taken_task", want.taken_task, got.taken_task);
      compare_field("taken_valid", 8'(want.taken_valid), 8'(got.taken_valid));
      compare_field("switched", 8'(want.switched), 8'(got.switched));
      compare_field("postponed", 8'(want.postponed), 8'(got.postponed));
      compare_field("dropped", 8'(want.dropped), 8'(got.dropped));
      compare_field("ready_count", 8'(want.ready_count), 8'(got.ready_count));
   endfunction
endclass

module round_robin_ready_queue_unit_test;
   import rrq_pkg::*;

   localparam int RANDOM_COMMANDS = 2000;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 4;        // the response is registered after acceptance

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_action = ACT_READ;
   logic [7:0] req_task_id = '0;
   logic       req_current_running = 1'b0;
   logic       req_switch_locked = 1'b0;
   logic       rsp_valid;
   logic [7:0] rsp_current_task;
   logic       rsp_current_valid;
   logic [7:0] rsp_taken_task;
   logic       rsp_taken_valid;
   logic       rsp_switched;
   logic       rsp_postponed;
   logic       rsp_dropped;
   logic [4:0] rsp_ready_count;

   int unsigned     cycle_count = 0;
   sched_scoreboard sb;

   round_robin_ready_queue_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_task_id         (req_task_id),
      .req_current_running (req_current_running),
      .req_switch_locked   (req_switch_locked),
      .rsp_valid           (rsp_valid),
      .rsp_current_task    (rsp_current_task),
      .rsp_current_valid   (rsp_current_valid),
      .rsp_taken_task      (rsp_taken_task),
      .rsp_taken_valid     (rsp_taken_valid),
      .rsp_switched        (rsp_switched),
      .rsp_postponed       (rsp_postponed),
      .rsp_dropped         (rsp_dropped),
      .rsp_ready_count     (rsp_ready_count)
   );

   always #4 clock = ~clock;

   // Watchdog: a hung handshake or a lost response ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Response monitor. Sampled at the edge that closes the strobe cycle, so
   // the values seen are the ones the block held during that cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_response({rsp_current_task, rsp_current_valid, rsp_taken_task,
                            rsp_taken_valid, rsp_switched, rsp_postponed,
                            rsp_dropped, rsp_ready_count});
   end

   // Issue one transaction. Called right after a rising edge; returns at the
   // edge that accepted it with start still high, so the caller either
   // chains the next transaction in the same step or lowers start.
   task automatic send_cmd(rrq_action_type act, logic [7:0] id,
                           bit still_running, bit locked);
      start               <= 1'b1;
      req_action          <= act;
      req_task_id         <= id;
      req_current_running <= still_running;
      req_switch_locked   <= locked;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_command(act, id, still_running, locked);
   endtask

   // Drop start and hold off until every outstanding response has arrived.
   task automatic wait_drained();
      start <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   // One random transaction; fill_bias steers the queue toward empty or full.
   task automatic send_random(int fill_bias);
      int             pick;
      int             add_share;
      rrq_action_type act;
      add_share = 25 + 25 * fill_bias;
      pick = $urandom_range(0, 99);
      if (pick < add_share)
         act = ACT_ADD;
      else if (pick < add_share + (100 - add_share) / 3)
         act = ACT_YIELD;
      else if (pick < add_share + 2 * (100 - add_share) / 3)
         act = ACT_TAKE;
      else
         act = ACT_READ;
      send_cmd(act, 8'($urandom_range(0, 255)), bit'($urandom_range(0, 1)),
               $urandom_range(0, 4) == 0);
   endtask

   initial begin
      int sent;
      int burst_len;
      int gap;
      int fill_bias;
      sb = new;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed corner cases ---
      send_cmd(ACT_READ,  8'h00, 1'b1, 1'b0);   // state right after reset
      send_cmd(ACT_YIELD, 8'h00, 1'b1, 1'b0);   // yield with empty queue
      send_cmd(ACT_TAKE,  8'h00, 1'b0, 1'b0);   // take with empty queue
      send_cmd(ACT_ADD,   8'hFF, 1'b1, 1'b1);   // first add, locked: postponed
      send_cmd(ACT_YIELD, 8'h00, 1'b1, 1'b1);   // locked yield, flag stays
      send_cmd(ACT_YIELD, 8'h00, 1'b1, 1'b0);   // no current task: not re-queued
      send_cmd(ACT_ADD,   8'hFF, 1'b1, 1'b0);   // switch to the same task number
      send_cmd(ACT_TAKE,  8'h00, 1'b1, 1'b0);   // take hits
      send_cmd(ACT_YIELD, 8'h00, 1'b0, 1'b0);   // blocked task, empty queue
      // fill to the brim; the first add becomes the current task, so no add is dropped
      for (int i = 0; i < 17; i++)
         send_cmd(ACT_ADD, 8'(i * 8'h11), i[0], 1'b0);
      send_cmd(ACT_YIELD, 8'h00, 1'b1, 1'b1);   // locked with full queue
      send_cmd(ACT_YIELD, 8'h00, 1'b1, 1'b0);   // rotate a full queue
      wait_drained();
      @(posedge clock);

      // --- random bursts ---
      sent = 0;
      while (sent < RANDOM_COMMANDS) begin
         burst_len = $urandom_range(1, 24);
         fill_bias = $urandom_range(0, 2);
         for (int k = 0; k < burst_len && sent < RANDOM_COMMANDS; k++) begin
            send_random(fill_bias);
            sent++;
         end
         // halfway through: sender goes quiet until the block has caught up
         if (sent >= RANDOM_COMMANDS / 2 && sent - burst_len < RANDOM_COMMANDS / 2) begin
            wait_drained();
            @(posedge clock);
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transactions: %0d task switches, %0d back takes, %0d dropped adds.",
               sb.commands, sb.switches, sb.takes_hit, sb.drops);
      $display("Peak ready-queue depth %0d, mismatches %0d.", sb.peak_depth, sb.mismatches);
      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/rrq_pkg.sv
src/rrq_cell.sv
src/round_robin_ready_queue_unit.sv
tb/round_robin_ready_queue_unit_test.sv
